// ----- hw/rtl/sipq_pkg.sv -----
// Shared definitions for the sorted-insert priority queue.
// Holds operation and status codes, default sizes and controller/datapath structs.
// No dependencies.
package sipq_pkg;

   // Default sizes, used as parameter defaults on the top level.
   localparam int DEPTH_DEFAULT          = 16;
   localparam int DATA_WIDTH_DEFAULT     = 32;
   localparam int PRIORITY_WIDTH_DEFAULT = 8;

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // register the incoming request
      logic execute;   // apply the held request to the cell array
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_held;  // a result is waiting and is not being taken
   } sts_type;

endpackage

// ----- hw/rtl/sorted_insert_priority_queue.sv -----
// Top level of the sorted-insert priority queue: controller plus datapath.
// Depends on sipq_pkg, sipq_ctrl and sipq_datapath.
//
// The queue holds up to DEPTH entries in a row of cells kept sorted by
// ascending priority; equal priorities leave in arrival order. Each request
// (push, pop, peek, clear) gives one result. A request is first registered;
// then every cell compares against the new priority in parallel and shifts
// in place. A new request is accepted while the previous result still waits;
// the execute step stalls only while the result register is occupied and not
// being taken. Cell contents are not reset, only the entry count and the
// result valid flag are, so no clearing pass is needed.
module sorted_insert_priority_queue #(
   parameter int DEPTH          = sipq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH     = sipq_pkg::DATA_WIDTH_DEFAULT,
   parameter int PRIORITY_WIDTH = sipq_pkg::PRIORITY_WIDTH_DEFAULT,
   localparam int CW            = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_opcode,
   input  logic [DATA_WIDTH-1:0]     req_item_data,
   input  logic [PRIORITY_WIDTH-1:0] req_item_priority,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [DATA_WIDTH-1:0]     rsp_head_data,
   output logic [PRIORITY_WIDTH-1:0] rsp_head_priority,
   output logic [1:0]                rsp_status,
   output logic [CW-1:0]             rsp_fill_count
);

   sipq_pkg::cmd_type cmd;
   sipq_pkg::sts_type sts;

   // Sequencing.
   sipq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Cell array and result register.
   sipq_datapath #(
      .DEPTH          (DEPTH),
      .DATA_WIDTH     (DATA_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_opcode        (req_opcode),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_head_data     (rsp_head_data),
      .rsp_head_priority (rsp_head_priority),
      .rsp_status        (rsp_status),
      .rsp_fill_count    (rsp_fill_count)
   );

   // A transferred request is executed before another is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while the previous one is still executing");

   // The count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fill_count <= CW'(DEPTH)))
      else $error("fill count exceeds depth");

   // A full error is reported only when the store is full.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == sipq_pkg::STATUS_FULL) |-> (rsp_fill_count == CW'(DEPTH)))
      else $error("full status with free space");

   // An empty error leaves an empty queue and zero head fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == sipq_pkg::STATUS_EMPTY) |->
         (rsp_fill_count == '0 && rsp_head_data == '0 && rsp_head_priority == '0))
      else $error("empty status with entries held or non-zero head");

endmodule

// ----- hw/rtl/sipq_ctrl.sv -----
// Controller state machine of the sorted-insert priority queue.
// Sequences request capture and execution; depends on sipq_pkg.
module sipq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sipq_pkg::sts_type sts,
   output sipq_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_WAIT = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // A new request is taken only while waiting.
   assign req_ready   = (state_ff == ST_WAIT);
   assign cmd.capture = req_valid && (state_ff == ST_WAIT);
   assign cmd.execute = (state_ff == ST_EXEC) && !sts.rsp_held;

   // Next-state logic: execution waits until the result register is free.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_WAIT: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!sts.rsp_held) begin
               state_in = ST_WAIT;
            end
         end
         default: state_in = ST_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/sipq_datapath.sv -----
// Datapath of the sorted-insert priority queue: request register, sorted cell
// array with parallel compare, entry count and result register. Depends on sipq_pkg.
module sipq_datapath #(
   parameter int DEPTH          = sipq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH     = sipq_pkg::DATA_WIDTH_DEFAULT,
   parameter int PRIORITY_WIDTH = sipq_pkg::PRIORITY_WIDTH_DEFAULT,
   localparam int CW            = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sipq_pkg::cmd_type         cmd,
   output sipq_pkg::sts_type         sts,
   input  logic [1:0]                req_opcode,
   input  logic [DATA_WIDTH-1:0]     req_item_data,
   input  logic [PRIORITY_WIDTH-1:0] req_item_priority,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [DATA_WIDTH-1:0]     rsp_head_data,
   output logic [PRIORITY_WIDTH-1:0] rsp_head_priority,
   output logic [1:0]                rsp_status,
   output logic [CW-1:0]             rsp_fill_count
);

   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // Held request.
   sipq_pkg::opcode_type      op_ff;
   logic [DATA_WIDTH-1:0]     data_req_ff;
   logic [PRIORITY_WIDTH-1:0] prio_req_ff;

   // Cell array and count.
   logic [DATA_WIDTH-1:0]     data_ff [DEPTH];
   logic [DATA_WIDTH-1:0]     data_in [DEPTH];
   logic [PRIORITY_WIDTH-1:0] prio_ff [DEPTH];
   logic [PRIORITY_WIDTH-1:0] prio_in [DEPTH];
   logic [DEPTH-1:0]          le;
   logic [CW-1:0]             count_ff, count_in;
   logic                      shift_insert, shift_pop;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]     rsp_data_ff, rsp_data_in;
   logic [PRIORITY_WIDTH-1:0] rsp_prio_ff, rsp_prio_in;
   sipq_pkg::status_type      rsp_status_ff, rsp_status_in;
   logic [CW-1:0]             rsp_count_ff;

   assign sts.rsp_held      = rsp_valid_ff && !rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_head_data     = rsp_data_ff;
   assign rsp_head_priority = rsp_prio_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_fill_count    = rsp_count_ff;

   // Operation decode: the count, shift commands and the result fields.
   always_comb begin
      count_in      = count_ff;
      shift_insert  = 1'b0;
      shift_pop     = 1'b0;
      rsp_data_in   = '0;
      rsp_prio_in   = '0;
      rsp_status_in = sipq_pkg::STATUS_OK;
      case (op_ff)
         sipq_pkg::OP_PUSH: begin
            if (count_ff == FULL_COUNT) begin
               rsp_status_in = sipq_pkg::STATUS_FULL;
            end else begin
               shift_insert = 1'b1;
               count_in     = count_ff + 1'b1;
            end
         end
         sipq_pkg::OP_POP, sipq_pkg::OP_PEEK: begin
            if (count_ff == '0) begin
               rsp_status_in = sipq_pkg::STATUS_EMPTY;
            end else begin
               rsp_data_in = data_ff[0];
               rsp_prio_in = prio_ff[0];
               if (op_ff == sipq_pkg::OP_POP) begin
                  shift_pop = 1'b1;
                  count_in  = count_ff - 1'b1;
               end
            end
         end
         sipq_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Each held cell compares its priority against the new one. Since the
   // array is sorted, the set of cells that stay put is a prefix.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         le[i] = (CW'(i) < count_ff) && (prio_ff[i] <= prio_req_ff);
      end
   end

   // Next value of every cell: keep, take the new entry, or shift by one place.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         data_in[i] = data_ff[i];
         prio_in[i] = prio_ff[i];
      end
      if (shift_insert) begin
         if (!le[0]) begin
            data_in[0] = data_req_ff;
            prio_in[0] = prio_req_ff;
         end
         for (int i = 1; i < DEPTH; i++) begin
            if (!le[i]) begin
               if (le[i-1]) begin
                  data_in[i] = data_req_ff;
                  prio_in[i] = prio_req_ff;
               end else begin
                  data_in[i] = data_ff[i-1];
                  prio_in[i] = prio_ff[i-1];
               end
            end
         end
      end else if (shift_pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            data_in[i] = data_ff[i+1];
            prio_in[i] = prio_ff[i+1];
         end
      end
   end

   // The result register is loaded on execute and cleared once transferred.
   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.execute) begin
            count_ff <= count_in;
         end
      end
   end

   // Payload registers: request, cells and result.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= sipq_pkg::opcode_type'(req_opcode);
         data_req_ff <= req_item_data;
         prio_req_ff <= req_item_priority;
      end
      if (cmd.execute) begin
         for (int i = 0; i < DEPTH; i++) begin
            data_ff[i] <= data_in[i];
            prio_ff[i] <= prio_in[i];
         end
         rsp_data_ff   <= rsp_data_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
      end
   end

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the sorted-insert priority queue.
// Depends on sipq_pkg and sorted_insert_priority_queue. A directed table runs first, then random
// traffic; each result is checked against a fixed table value or a behavioural copy of the queue.
module testbench;

   localparam int DEPTH          = sipq_pkg::DEPTH_DEFAULT;
   localparam int DW             = sipq_pkg::DATA_WIDTH_DEFAULT;
   localparam int PW             = sipq_pkg::PRIORITY_WIDTH_DEFAULT;
   localparam int CW             = $clog2(DEPTH + 1);
   localparam int RANDOM_ITEMS   = 1000;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int BACKLOG_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 10;

   // One result transfer, field by field.
   typedef struct packed {
      logic [DW-1:0]        head_data;
      logic [PW-1:0]        head_prio;
      sipq_pkg::status_type status;
      logic [CW-1:0]        fill_count;
   } queue_result_type;

   // One line of the directed table; the data word is stepped by one for each copy.
   typedef struct {
      int                   copies;
      sipq_pkg::opcode_type op;
      logic [DW-1:0]        data;
      logic [PW-1:0]        prio;
      bit                   fixed;
      queue_result_type     fixed_result;
   } directed_row_type;

   logic          clock             = 1'b0;
   logic          reset             = 1'b1;
   logic          req_valid         = 1'b0;
   logic          req_ready;
   logic [1:0]    req_opcode        = sipq_pkg::OP_PUSH;
   logic [DW-1:0] req_item_data     = '0;
   logic [PW-1:0] req_item_priority = '0;
   logic          rsp_valid;
   logic          rsp_ready         = 1'b0;
   logic [DW-1:0] rsp_head_data;
   logic [PW-1:0] rsp_head_priority;
   logic [1:0]    rsp_status;
   logic [CW-1:0] rsp_fill_count;

   // Behavioural copy of the queue contents and the results still to arrive.
   logic [DW-1:0]    shadow_data [DEPTH];
   logic [PW-1:0]    shadow_prio [DEPTH];
   int               shadow_count = 0;
   queue_result_type pending_results [$];

   int          failures      = 0;
   int          results_seen  = 0;
   int          cycle_count   = 0;
   bit          steady_flow   = 1'b0;
   bit          backlog_done  = 1'b0;
   int unsigned backlog_left  = 0;

   // Directed cases: empty reads after reset, field extremes, equal priorities,
   // insertion in the middle, clear, and a push into a full store.
   directed_row_type directed_rows [22] = '{
      '{1,  sipq_pkg::OP_POP,   32'h0000_0000, 8'h00, 1'b1,
         '{32'h0, 8'h00, sipq_pkg::STATUS_EMPTY, CW'(0)}},
      '{1,  sipq_pkg::OP_PEEK,  32'hFFFF_FFFF, 8'hFF, 1'b1,
         '{32'h0, 8'h00, sipq_pkg::STATUS_EMPTY, CW'(0)}},
      '{1,  sipq_pkg::OP_CLEAR, 32'h0000_0000, 8'h00, 1'b1,
         '{32'h0, 8'h00, sipq_pkg::STATUS_OK, CW'(0)}},
      '{1,  sipq_pkg::OP_PUSH,  32'hFFFF_FFFF, 8'hFF, 1'b1,
         '{32'h0, 8'h00, sipq_pkg::STATUS_OK, CW'(1)}},
      '{1,  sipq_pkg::OP_PEEK,  32'h0000_0000, 8'h00, 1'b1,
         '{32'hFFFF_FFFF, 8'hFF, sipq_pkg::STATUS_OK, CW'(1)}},
      '{1,  sipq_pkg::OP_PUSH,  32'h0000_0000, 8'h00, 1'b1,
         '{32'h0, 8'h00, sipq_pkg::STATUS_OK, CW'(2)}},
      '{1,  sipq_pkg::OP_PEEK,  32'h0000_0000, 8'h00, 1'b1,
         '{32'h0, 8'h00, sipq_pkg::STATUS_OK, CW'(2)}},
      '{1,  sipq_pkg::OP_PUSH,  32'hA5A5_A5A5, 8'hFF, 1'b0, '0},
      '{1,  sipq_pkg::OP_PUSH,  32'h5A5A_5A5A, 8'h00, 1'b0, '0},
      '{1,  sipq_pkg::OP_PUSH,  32'h1234_5678, 8'h80, 1'b0, '0},
      '{5,  sipq_pkg::OP_POP,   32'h0000_0000, 8'h00, 1'b0, '0},
      '{1,  sipq_pkg::OP_POP,   32'h0000_0000, 8'h00, 1'b1,
         '{32'h0, 8'h00, sipq_pkg::STATUS_EMPTY, CW'(0)}},
      '{3,  sipq_pkg::OP_PUSH,  32'hDEAD_BEEF, 8'h07, 1'b0, '0},
      '{1,  sipq_pkg::OP_CLEAR, 32'h0000_0000, 8'h00, 1'b1,
         '{32'h0, 8'h00, sipq_pkg::STATUS_OK, CW'(0)}},
      '{1,  sipq_pkg::OP_PEEK,  32'h0000_0000, 8'h00, 1'b1,
         '{32'h0, 8'h00, sipq_pkg::STATUS_EMPTY, CW'(0)}},
      '{16, sipq_pkg::OP_PUSH,  32'hC0DE_0000, 8'h55, 1'b0, '0},
      '{1,  sipq_pkg::OP_PUSH,  32'h0000_0001, 8'h00, 1'b1,
         '{32'h0, 8'h00, sipq_pkg::STATUS_FULL, CW'(16)}},
      '{1,  sipq_pkg::OP_PEEK,  32'h0000_0000, 8'h00, 1'b0, '0},
      '{1,  sipq_pkg::OP_POP,   32'h0000_0000, 8'h00, 1'b0, '0},
      '{1,  sipq_pkg::OP_PUSH,  32'hFFFF_FFFF, 8'hFF, 1'b1,
         '{32'h0, 8'h00, sipq_pkg::STATUS_OK, CW'(16)}},
      '{1,  sipq_pkg::OP_PUSH,  32'h0000_0000, 8'h00, 1'b1,
         '{32'h0, 8'h00, sipq_pkg::STATUS_FULL, CW'(16)}},
      '{1,  sipq_pkg::OP_CLEAR, 32'h0000_0000, 8'h00, 1'b1,
         '{32'h0, 8'h00, sipq_pkg::STATUS_OK, CW'(0)}}
   };

   sorted_insert_priority_queue uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_head_data     (rsp_head_data),
      .rsp_head_priority (rsp_head_priority),
      .rsp_status        (rsp_status),
      .rsp_fill_count    (rsp_fill_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Applies one operation to the shadow queue and returns the result it should give.
   function automatic queue_result_type advance_shadow_queue(sipq_pkg::opcode_type op,
                                                             logic [DW-1:0] d,
                                                             logic [PW-1:0] p);
      queue_result_type r;
      int               slot;
      r = '0;
      r.status = sipq_pkg::STATUS_OK;
      case (op)
         sipq_pkg::OP_PUSH: begin
            if (shadow_count >= DEPTH) begin
               r.status = sipq_pkg::STATUS_FULL;
            end else begin
               // The new entry goes after every entry of lower or equal priority.
               slot = 0;
               while (slot < shadow_count && shadow_prio[slot] <= p) slot++;
               for (int i = shadow_count; i > slot; i--) begin
                  shadow_data[i] = shadow_data[i - 1];
                  shadow_prio[i] = shadow_prio[i - 1];
               end
               shadow_data[slot] = d;
               shadow_prio[slot] = p;
               shadow_count++;
            end
         end
         sipq_pkg::OP_POP, sipq_pkg::OP_PEEK: begin
            if (shadow_count == 0) begin
               r.status = sipq_pkg::STATUS_EMPTY;
            end else begin
               r.head_data = shadow_data[0];
               r.head_prio = shadow_prio[0];
               if (op == sipq_pkg::OP_POP) begin
                  for (int i = 0; i + 1 < shadow_count; i++) begin
                     shadow_data[i] = shadow_data[i + 1];
                     shadow_prio[i] = shadow_prio[i + 1];
                  end
                  shadow_count--;
               end
            end
         end
         default: begin
            shadow_count = 0;
         end
      endcase
      r.fill_count = CW'(shadow_count);
      return r;
   endfunction

   // Offers one request, waits for its transfer, records the expected result,
   // and then may leave the channel idle for a while.
   task automatic offer_request(sipq_pkg::opcode_type op, logic [DW-1:0] d,
                                logic [PW-1:0] p, bit fixed,
                                queue_result_type fixed_result, bit may_idle);
      queue_result_type predicted;
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_item_data     <= d;
      req_item_priority <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_shadow_queue(op, d, p);
      pending_results.push_back(fixed ? fixed_result : predicted);
      while (may_idle && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Request side: reset, the directed table, then random traffic in phases that lean
   // towards pushes, lean towards pops or are balanced, so that the queue reaches both full and empty.
   initial begin
      sipq_pkg::opcode_type op;
      logic [PW-1:0]        p;
      int                   push_weight;
      bit                   steady;
      push_weight = 50;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].copies; k++) begin
            offer_request(directed_rows[r].op, directed_rows[r].data + DW'(k),
                          directed_rows[r].prio, directed_rows[r].fixed,
                          directed_rows[r].fixed_result, 1'b1);
         end
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_weight = 85;
               1:       push_weight = 50;
               default: push_weight = 20;
            endcase
         end
         // A stretch in the middle runs with neither side idling.
         steady = (n >= 400 && n < 600);
         steady_flow <= steady;

         if ($urandom_range(0, 99) < 2) begin
            op = sipq_pkg::OP_CLEAR;
         end else if ($urandom_range(0, 99) < push_weight) begin
            op = sipq_pkg::OP_PUSH;
         end else if ($urandom_range(0, 3) == 0) begin
            op = sipq_pkg::OP_PEEK;
         end else begin
            op = sipq_pkg::OP_POP;
         end

         // Narrow priorities give many ties; the rest are the two extremes or span the whole range.
         case ($urandom_range(0, 3))
            0:       p = PW'($urandom);
            1:       p = ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: p = PW'($urandom_range(0, 3));
         endcase

         offer_request(op, DW'($urandom), p, 1'b0, '0, !steady);
      end
      req_valid   <= 1'b0;
      steady_flow <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Result side: random stalls, one long hold-off that backs the queue up, and
   // no stalls while the steady stretch runs.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (backlog_left != 0) begin
         rsp_ready    <= 1'b0;
         backlog_left <= backlog_left - 1;
      end else if (!backlog_done && results_seen >= 100) begin
         backlog_done <= 1'b1;
         backlog_left <= BACKLOG_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (steady_flow) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 25);
      end
   end

   // Each result transfer is compared with the oldest expected result.
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (pending_results.size() == 0) begin
            $error("unexpected result: head_data %h, head_priority %h, status %0d",
                   rsp_head_data, rsp_head_priority, rsp_status);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_head_data !== want.head_data) begin
               $error("head_data: expected %h, actual %h", want.head_data, rsp_head_data);
               failures++;
            end
            if (rsp_head_priority !== want.head_prio) begin
               $error("head_priority: expected %h, actual %h", want.head_prio,
                      rsp_head_priority);
               failures++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_fill_count !== want.fill_count) begin
               $error("fill_count: expected %0d, actual %0d", want.fill_count,
                      rsp_fill_count);
               failures++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sorted_insert_priority_queue.f -----
hw/rtl/sipq_pkg.sv
hw/rtl/sipq_ctrl.sv
hw/rtl/sipq_datapath.sv
hw/rtl/sorted_insert_priority_queue.sv
test/testbench.sv
